// ----- hdl/scf_pkg.sv -----
// shared types and constants of the servo command framer
`default_nettype none

package scf_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_DUTY_FLOOR    = 3'd0;
    localparam logic [2:0] CFG_DUTY_CEIL     = 3'd1;
    localparam logic [2:0] CFG_HEADER_FIRST  = 3'd2;
    localparam logic [2:0] CFG_HEADER_SECOND = 3'd3;
    localparam logic [2:0] CFG_FUNCTION_CODE = 3'd4;
    localparam logic [2:0] CFG_COMMAND_CODE  = 3'd5;

    // configuration reset values
    localparam logic [15:0] DUTY_FLOOR_RST    = 16'd500;
    localparam logic [15:0] DUTY_CEIL_RST     = 16'd2500;
    localparam logic [7:0]  HEADER_FIRST_RST  = 8'd170;
    localparam logic [7:0]  HEADER_SECOND_RST = 8'd85;
    localparam logic [7:0]  FUNCTION_CODE_RST = 8'd4;
    localparam logic [7:0]  COMMAND_CODE_RST  = 8'd1;

    // fixed part of the length byte
    localparam logic [7:0] LEN_BASE = 8'd7;

    // byte positions of a frame, one per output byte
    localparam logic [3:0] STEP_HEADER_FIRST  = 4'd0;
    localparam logic [3:0] STEP_HEADER_SECOND = 4'd1;
    localparam logic [3:0] STEP_FUNCTION      = 4'd2;
    localparam logic [3:0] STEP_LENGTH        = 4'd3;
    localparam logic [3:0] STEP_COMMAND       = 4'd4;
    localparam logic [3:0] STEP_COUNT         = 4'd5;
    localparam logic [3:0] STEP_TIME_LOW      = 4'd6;
    localparam logic [3:0] STEP_TIME_HIGH     = 4'd7;
    localparam logic [3:0] STEP_SERVO_ID      = 4'd8;
    localparam logic [3:0] STEP_DUTY_LOW      = 4'd9;
    localparam logic [3:0] STEP_DUTY_HIGH     = 4'd10;
    localparam logic [3:0] STEP_CHECKSUM      = 4'd11;

    // configuration register set
    typedef struct packed {
        logic [15:0] duty_floor;
        logic [15:0] duty_ceil;
        logic [7:0]  header_first;
        logic [7:0]  header_second;
        logic [7:0]  function_code;
        logic [7:0]  command_code;
    } cfg_t;

    // classified work for the byte emitter
    typedef struct packed {
        logic        rejected;
        logic        first;
        logic        last;
        logic [7:0]  count;
        logic [7:0]  length;
        logic [15:0] move_time;
        logic [7:0]  servo_id;
        logic [15:0] duty;
    } job_t;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       rejected;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/servo_command_framer_unit.sv -----
// top level of the servo command framer: configuration registers and block wiring
//
// Each accepted item is one servo entry; the item that starts a frame also carries
// the servo count and move time. The block streams the frame out one byte per
// result item: two header bytes, function code, length (7+3n), command code, count,
// move time low/high, then per entry the servo id and the clamped duty low/high, and
// after the last entry the 8-bit sum of all preceding frame bytes. A start item with a count
// of zero or above MAX_SERVOS gives one result with rejected set and no frame.
// The front end takes one item per cycle while its two-entry job queue has room;
// the byte emitter in the back end produces one result byte per cycle while the
// output buffer has room, so a start item yields 11 or 12 bytes, a later entry 3
// or 4, a rejected start one. The emitter's one-byte-per-cycle output sets the
// sustained rate. Results wait in a two-entry output buffer. The configuration
// port is always ready; indexes above 5 are ignored.
`default_nettype none

module servo_command_framer_unit import scf_pkg::*; #(
    parameter int MAX_SERVOS = 21
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        frame_start,
    input  wire logic [7:0]  servo_count,
    input  wire logic [15:0] move_time,
    input  wire logic [7:0]  servo_id,
    input  wire logic [15:0] duty,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             run_end,
    output logic             rejected,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t cfg_reg;
    logic q_full;
    logic q_push;
    job_t q_wr_job;
    logic q_empty;
    logic q_pop;
    job_t q_rd_job;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.duty_floor    <= DUTY_FLOOR_RST;
            cfg_reg.duty_ceil     <= DUTY_CEIL_RST;
            cfg_reg.header_first  <= HEADER_FIRST_RST;
            cfg_reg.header_second <= HEADER_SECOND_RST;
            cfg_reg.function_code <= FUNCTION_CODE_RST;
            cfg_reg.command_code  <= COMMAND_CODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DUTY_FLOOR:    cfg_reg.duty_floor    <= cfg_data;
                CFG_DUTY_CEIL:     cfg_reg.duty_ceil     <= cfg_data;
                CFG_HEADER_FIRST:  cfg_reg.header_first  <= cfg_data[7:0];
                CFG_HEADER_SECOND: cfg_reg.header_second <= cfg_data[7:0];
                CFG_FUNCTION_CODE: cfg_reg.function_code <= cfg_data[7:0];
                CFG_COMMAND_CODE:  cfg_reg.command_code  <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // item classification
    scf_front #(
        .MAX_SERVOS (MAX_SERVOS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .frame_start (frame_start),
        .servo_count (servo_count),
        .move_time   (move_time),
        .servo_id    (servo_id),
        .duty        (duty),
        .cfg         (cfg_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (q_wr_job)
    );

    // job queue
    scf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_job),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_job),
        .empty   (q_empty)
    );

    // byte emitter
    scf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_job    (q_rd_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .run_end  (run_end),
        .rejected (rejected)
    );

endmodule

`default_nettype wire

// ----- hdl/scf_front.sv -----
// front end: accepts items, tracks frame state, clamps duty and builds jobs
`default_nettype none

module scf_front import scf_pkg::*; #(
    parameter int MAX_SERVOS = 21
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        frame_start,
    input  wire logic [7:0]  servo_count,
    input  wire logic [15:0] move_time,
    input  wire logic [7:0]  servo_id,
    input  wire logic [15:0] duty,
    input  wire cfg_t        cfg,
    input  wire logic        q_full,
    output logic             q_push,
    output job_t             q_job
);

    logic       in_frame_reg;
    logic       in_frame_next;
    logic [4:0] entries_left_reg;
    logic [4:0] entries_left_next;
    logic       accept;
    logic       bad_count;
    logic [7:0] count_x3;
    logic [15:0] duty_clamped;

    assign accept    = push && !q_full;
    assign bad_count = (servo_count == 8'd0) || (servo_count > 8'(MAX_SERVOS));
    assign count_x3  = (servo_count << 1) + servo_count;

    // clamp against the configured limits, lower limit first
    always_comb
    begin
        if (duty < cfg.duty_floor)
            duty_clamped = cfg.duty_floor;
        else if (duty > cfg.duty_ceil)
            duty_clamped = cfg.duty_ceil;
        else
            duty_clamped = duty;
    end

    // job for the back end
    always_comb
    begin
        q_push             = accept && (frame_start || in_frame_reg);
        q_job.rejected     = frame_start && bad_count;
        q_job.first        = frame_start;
        q_job.last         = frame_start ? (servo_count == 8'd1) : (entries_left_reg == 5'd1);
        q_job.count        = servo_count;
        q_job.length       = LEN_BASE + count_x3;
        q_job.move_time    = move_time;
        q_job.servo_id     = servo_id;
        q_job.duty         = duty_clamped;
    end

    // frame tracking
    always_comb
    begin
        in_frame_next     = in_frame_reg;
        entries_left_next = entries_left_reg;
        if (accept)
        begin
            if (frame_start)
            begin
                if (bad_count)
                begin
                    in_frame_next     = 1'b0;
                    entries_left_next = 5'd0;
                end
                else
                begin
                    in_frame_next     = (servo_count != 8'd1);
                    entries_left_next = servo_count[4:0] - 5'd1;
                end
            end
            else if (in_frame_reg)
            begin
                in_frame_next     = (entries_left_reg != 5'd1);
                entries_left_next = entries_left_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg     <= 1'b0;
            entries_left_reg <= 5'd0;
        end
        else
        begin
            in_frame_reg     <= in_frame_next;
            entries_left_reg <= entries_left_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/scf_queue.sv -----
// two-entry job queue between front and back end
`default_nettype none

module scf_queue import scf_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire job_t wr_data,
    output logic      full,
    input  wire logic rd_en,
    output job_t      rd_data,
    output logic      empty
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 2'd1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 2'd1;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// ----- hdl/scf_back.sv -----
// back end: walks each job byte by byte, keeps the checksum, buffers results
`default_nettype none

module scf_back import scf_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire job_t  q_job,
    input  wire logic  q_empty,
    output logic       q_pop,
    output logic       empty,
    input  wire logic  pop,
    output logic [7:0] out_byte,
    output logic       run_end,
    output logic       rejected
);

    logic       active_reg;
    logic       active_next;
    job_t       job_reg;
    logic [3:0] step_reg;
    logic [3:0] step_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;

    result_t    obuf_reg [2];
    logic       owr_ptr_reg;
    logic       ord_ptr_reg;
    logic [1:0] ocount_reg;
    logic [1:0] ocount_next;

    logic       obuf_full;
    logic       emit;
    logic       done;
    logic       load;
    logic [3:0] last_step;
    logic [7:0] frame_byte;
    result_t    res;
    logic       opop;

    assign obuf_full = (ocount_reg == 2'd2);
    assign emit      = active_reg && !obuf_full;
    assign last_step = job_reg.last ? STEP_CHECKSUM : STEP_DUTY_HIGH;
    assign done      = emit && (job_reg.rejected || (step_reg == last_step));
    assign load      = !q_empty && (!active_reg || done);
    assign q_pop     = load;
    assign opop      = pop && (ocount_reg != 2'd0);

    // byte selection by frame position
    always_comb
    begin
        case (step_reg)
            STEP_HEADER_FIRST:  frame_byte = cfg.header_first;
            STEP_HEADER_SECOND: frame_byte = cfg.header_second;
            STEP_FUNCTION:      frame_byte = cfg.function_code;
            STEP_LENGTH:        frame_byte = job_reg.length;
            STEP_COMMAND:       frame_byte = cfg.command_code;
            STEP_COUNT:         frame_byte = job_reg.count;
            STEP_TIME_LOW:      frame_byte = job_reg.move_time[7:0];
            STEP_TIME_HIGH:     frame_byte = job_reg.move_time[15:8];
            STEP_SERVO_ID:      frame_byte = job_reg.servo_id;
            STEP_DUTY_LOW:      frame_byte = job_reg.duty[7:0];
            STEP_DUTY_HIGH:     frame_byte = job_reg.duty[15:8];
            STEP_CHECKSUM:      frame_byte = sum_reg;
            default:            frame_byte = 8'd0;
        endcase
    end

    // result item being produced
    always_comb
    begin
        res.out_byte = job_reg.rejected ? 8'd0 : frame_byte;
        res.run_end  = job_reg.rejected || (step_reg == last_step);
        res.rejected = job_reg.rejected;
    end

    // sequencing and checksum
    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        sum_next    = sum_reg;
        if (emit && !job_reg.rejected)
        begin
            step_next = step_reg + 4'd1;
            if (step_reg == STEP_CHECKSUM)
                sum_next = 8'd0;
            else if (step_reg == STEP_HEADER_FIRST)
                sum_next = frame_byte;
            else
                sum_next = sum_reg + frame_byte;
        end
        if (load)
        begin
            active_next = 1'b1;
            step_next   = q_job.first ? STEP_HEADER_FIRST : STEP_SERVO_ID;
        end
        else if (done)
            active_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= STEP_HEADER_FIRST;
            sum_reg    <= 8'd0;
        end
        else
        begin
            active_reg <= active_next;
            step_reg   <= step_next;
            sum_reg    <= sum_next;
        end
    end

    // current job payload
    always_ff @(posedge clk)
    begin
        if (load)
            job_reg <= q_job;
    end

    // output buffer occupancy
    always_comb
    begin
        ocount_next = ocount_reg;
        if (emit && !opop)
            ocount_next = ocount_reg + 2'd1;
        else if (opop && !emit)
            ocount_next = ocount_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_ptr_reg <= 1'b0;
            ord_ptr_reg <= 1'b0;
            ocount_reg  <= 2'd0;
        end
        else
        begin
            if (emit)
                owr_ptr_reg <= !owr_ptr_reg;
            if (opop)
                ord_ptr_reg <= !ord_ptr_reg;
            ocount_reg <= ocount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            obuf_reg[owr_ptr_reg] <= res;
    end

    // result ports
    assign empty    = (ocount_reg == 2'd0);
    assign out_byte = obuf_reg[ord_ptr_reg].out_byte;
    assign run_end  = obuf_reg[ord_ptr_reg].run_end;
    assign rejected = obuf_reg[ord_ptr_reg].rejected;

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// self-checking testbench for the servo command framer unit
module testbench;
    import scf_pkg::*;

    localparam int SERVO_LIMIT    = 21;
    localparam int SETTLE_CYCLES  = 24;
    localparam int STALL_LIMIT    = 1000;
    localparam int RANDOM_ENTRIES = 360;
    localparam int REPORT_LIMIT   = 100;

    // indexes past the last register, written to check that they are ignored
    localparam logic [2:0] CFG_UNUSED_LOW  = 3'd6;
    localparam logic [2:0] CFG_UNUSED_HIGH = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        frame_start = 1'b0;
    logic [7:0]  servo_count = '0;
    logic [15:0] move_time = '0;
    logic [7:0]  servo_id = '0;
    logic [15:0] duty = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  out_byte;
    logic        run_end;
    logic        rejected;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_DUTY_FLOOR;
    logic [15:0] cfg_data = '0;

    servo_command_framer_unit #(
        .MAX_SERVOS(SERVO_LIMIT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .frame_start(frame_start),
        .servo_count(servo_count),
        .move_time(move_time),
        .servo_id(servo_id),
        .duty(duty),
        .empty(empty),
        .pop(pop),
        .out_byte(out_byte),
        .run_end(run_end),
        .rejected(rejected),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // framer state as the bench sees it
    cfg_t       shadow_cfg;
    logic       frame_open;
    logic [4:0] entries_owed;
    logic [7:0] byte_sum;
    result_t    frame_bytes_due[$];
    result_t    byte_due;

    int  entries_sent = 0;
    int  frames_started = 0;
    int  frames_refused = 0;
    int  reg_writes = 0;
    int  bytes_checked = 0;
    int  mismatch_count = 0;
    int  rx_hold = 0;
    int  quiet_cycles = 0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;

    // clock
    initial forever #1 clk = ~clk;

    // idle length: mostly none or short, now and then long
    function automatic int idle_length(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // duty values around both clamp limits, the extremes and anywhere
    function automatic logic [15:0] pick_duty();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return 16'($urandom);
        if (r < 55) return shadow_cfg.duty_floor + 16'($urandom_range(0, 4)) - 16'd2;
        if (r < 75) return shadow_cfg.duty_ceil + 16'($urandom_range(0, 4)) - 16'd2;
        if (r < 85) return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom_range(0, 3000));
    endfunction

    // bytes that one accepted entry puts on the line; returns how many
    function automatic int frame_predict(input logic st, input logic [7:0] cnt,
                                         input logic [15:0] mt, input logic [7:0] id,
                                         input logic [15:0] d);
        logic [7:0]  seq[$];
        logic [15:0] clamped;
        result_t     r;
        // bad count: single refusal, any open frame dropped
        if (st && (cnt == 8'd0 || cnt > SERVO_LIMIT)) begin
            frame_open = 1'b0;
            entries_owed = '0;
            byte_sum = '0;
            r.out_byte = '0;
            r.run_end = 1'b1;
            r.rejected = 1'b1;
            frame_bytes_due.push_back(r);
            frames_refused++;
            return 1;
        end
        if (!st && !frame_open) return 0;
        // frame head on a start entry
        if (st) begin
            byte_sum = '0;
            seq.push_back(shadow_cfg.header_first);
            seq.push_back(shadow_cfg.header_second);
            seq.push_back(shadow_cfg.function_code);
            seq.push_back(LEN_BASE + 8'd3 * cnt);
            seq.push_back(shadow_cfg.command_code);
            seq.push_back(cnt);
            seq.push_back(mt[7:0]);
            seq.push_back(mt[15:8]);
            frame_open = 1'b1;
            entries_owed = cnt[4:0];
            frames_started++;
        end
        // servo entry with clamped duty
        if (d < shadow_cfg.duty_floor) clamped = shadow_cfg.duty_floor;
        else if (d > shadow_cfg.duty_ceil) clamped = shadow_cfg.duty_ceil;
        else clamped = d;
        seq.push_back(id);
        seq.push_back(clamped[7:0]);
        seq.push_back(clamped[15:8]);
        foreach (seq[i]) byte_sum = byte_sum + seq[i];
        entries_owed = entries_owed - 5'd1;
        // checksum closes the frame
        if (entries_owed == '0) begin
            seq.push_back(byte_sum);
            frame_open = 1'b0;
            byte_sum = '0;
        end
        foreach (seq[i]) begin
            r.out_byte = seq[i];
            r.run_end = (i == seq.size() - 1);
            r.rejected = 1'b0;
            frame_bytes_due.push_back(r);
        end
        return seq.size();
    endfunction

    // hand one entry to the framer
    task automatic send_entry(input logic st, input logic [7:0] cnt, input logic [15:0] mt,
                              input logic [7:0] id, input logic [15:0] d);
        int gap;
        gap = idle_length(tx_calm);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        frame_start <= st;
        servo_count <= cnt;
        move_time <= mt;
        servo_id <= id;
        duty <= d;
        do @(posedge clk); while (full);
        if (frame_predict(st, cnt, mt, id, d) > 0) entries_sent++;
    endtask

    // start entry announcing n servos, then the rest up to sent entries in total
    task automatic send_frame(input int n, input int sent);
        for (int i = 0; i < sent; i++) begin
            if (i == 0)
                send_entry(1'b1, 8'(n), 16'($urandom), 8'($urandom), pick_duty());
            else
                send_entry(1'b0, 8'($urandom), 16'($urandom), 8'($urandom), pick_duty());
        end
    endtask

    // hold the sender until every byte is out and the framer has gone quiet
    task automatic wait_idle();
        push <= 1'b0;
        while (frame_bytes_due.size() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write, valid left high for the caller to drop
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_DUTY_FLOOR:    shadow_cfg.duty_floor = val;
            CFG_DUTY_CEIL:     shadow_cfg.duty_ceil = val;
            CFG_HEADER_FIRST:  shadow_cfg.header_first = val[7:0];
            CFG_HEADER_SECOND: shadow_cfg.header_second = val[7:0];
            CFG_FUNCTION_CODE: shadow_cfg.function_code = val[7:0];
            CFG_COMMAND_CODE:  shadow_cfg.command_code = val[7:0];
            default:           ;
        endcase
        reg_writes++;
    endtask

    // full register set; byte registers get junk in their upper half
    task automatic program_config(input cfg_t c, input bit poke_unused);
        write_reg(CFG_DUTY_FLOOR, c.duty_floor);
        write_reg(CFG_DUTY_CEIL, c.duty_ceil);
        write_reg(CFG_HEADER_FIRST, {8'($urandom), c.header_first});
        write_reg(CFG_HEADER_SECOND, {8'($urandom), c.header_second});
        write_reg(CFG_FUNCTION_CODE, {8'($urandom), c.function_code});
        write_reg(CFG_COMMAND_CODE, {8'($urandom), c.command_code});
        if (poke_unused) begin
            write_reg(CFG_UNUSED_LOW, 16'($urandom));
            write_reg(CFG_UNUSED_HIGH, 16'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        if (mismatch_count == REPORT_LIMIT)
            $display("%0t: further mismatches not shown", $time);
    endtask

    // frames under reset settings, single servo case included
    task automatic test_reset_defaults();
        send_entry(1'b1, 8'd1, 16'h0000, 8'h00, 16'h0000);
        send_entry(1'b1, 8'd2, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_entry(1'b0, 8'hFF, 16'hFFFF, 8'h5A, DUTY_FLOOR_RST);
        send_entry(1'b1, 8'd2, 16'h1234, 8'hA5, DUTY_CEIL_RST);
        send_entry(1'b0, 8'h00, 16'h0000, 8'h01, 16'd1234);
        // stray entry with no frame open
        send_entry(1'b0, 8'd3, 16'h0101, 8'h77, 16'd1000);
        wait_idle();
    endtask

    // counts of zero and above the limit are refused
    task automatic test_bad_counts();
        send_entry(1'b1, 8'd0, 16'h00FF, 8'h11, 16'd900);
        send_entry(1'b1, 8'(SERVO_LIMIT + 1), 16'hFF00, 8'h22, 16'd900);
        send_entry(1'b1, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF);
        wait_idle();
    endtask

    // open frames cut short by a refusal or by a new start
    task automatic test_dropped_frames();
        send_frame(3, 1);
        send_entry(1'b1, 8'd0, 16'h4321, 8'h33, 16'd700);
        send_entry(1'b0, 8'd1, 16'h0000, 8'h44, 16'd800);
        send_frame(2, 1);
        send_frame(1, 1);
        send_frame(4, 2);
        send_frame(2, 2);
        wait_idle();
    endtask

    // widest window, crossed limits and ignored register indexes
    task automatic test_config_extremes();
        cfg_t c;
        c = {16'h0000, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00};
        program_config(c, 1'b0);
        send_entry(1'b1, 8'd1, 16'h8001, 8'h80, 16'hFFFF);
        send_entry(1'b1, 8'd1, 16'h7FFE, 8'h7F, 16'h0000);
        wait_idle();
        c = {16'hFFFF, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        program_config(c, 1'b1);
        send_entry(1'b1, 8'd2, 16'hFFFF, 8'hFF, 16'h0001);
        send_entry(1'b0, 8'd2, 16'hFFFF, 8'hFE, 16'hFFFF);
        wait_idle();
    endtask

    // random frames over several register settings and traffic patterns
    task automatic test_random_frames();
        cfg_t c;
        int   target;
        int   r;
        int   n;
        for (int phase = 0; phase < 4; phase++) begin
            tx_calm = (phase == 1) || (phase == 3);
            rx_calm = (phase == 2) || (phase == 3);
            c.header_first = 8'($urandom);
            c.header_second = 8'($urandom);
            c.function_code = 8'($urandom);
            c.command_code = 8'($urandom);
            case (phase)
                0: begin
                    c.duty_floor = 16'($urandom_range(0, 1500));
                    c.duty_ceil = 16'($urandom_range(1500, 4000));
                end
                1: begin
                    c.duty_floor = 16'h0000;
                    c.duty_ceil = 16'hFFFF;
                end
                2: begin
                    c.duty_floor = 16'($urandom);
                    c.duty_ceil = 16'($urandom);
                end
                default: begin
                    c.duty_floor = 16'($urandom);
                    c.duty_ceil = c.duty_floor;
                end
            endcase
            program_config(c, phase % 2 == 1);
            target = entries_sent + RANDOM_ENTRIES / 4;
            // largest frame the block takes
            if (phase == 0) send_frame(SERVO_LIMIT, SERVO_LIMIT);
            while (entries_sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 78) begin
                    n = $urandom_range(0, 99);
                    if (n < 70) n = $urandom_range(1, 4);
                    else if (n < 95) n = $urandom_range(5, SERVO_LIMIT - 1);
                    else n = SERVO_LIMIT;
                    send_frame(n, n);
                end else if (r < 86) begin
                    n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(SERVO_LIMIT + 1, 255);
                    send_entry(1'b1, 8'(n), 16'($urandom), 8'($urandom), 16'($urandom));
                end else if (r < 94) begin
                    n = $urandom_range(2, 8);
                    send_frame(n, $urandom_range(1, n - 1));
                end else begin
                    send_entry(1'b0, 8'($urandom), 16'($urandom), 8'($urandom), pick_duty());
                end
            end
            wait_idle();
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // result side: random pop stalls and field checks
    always @(posedge clk) begin
        if (rst_n && pop && !empty) begin
            bytes_checked++;
            if (frame_bytes_due.size() == 0) begin
                report_mismatch("unexpected item, out_byte", 8'h00, out_byte);
            end else begin
                byte_due = frame_bytes_due.pop_front();
                if (out_byte !== byte_due.out_byte)
                    report_mismatch("out_byte", byte_due.out_byte, out_byte);
                if (run_end !== byte_due.run_end)
                    report_mismatch("run_end", 8'(byte_due.run_end), 8'(run_end));
                if (rejected !== byte_due.rejected)
                    report_mismatch("rejected", 8'(byte_due.rejected), 8'(rejected));
            end
            rx_hold = idle_length(rx_calm);
        end
        if (rx_hold > 0) begin
            pop <= 1'b0;
            rx_hold--;
        end else begin
            pop <= rst_n;
        end
    end

    // watchdog on cycles where nothing is handed over
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: nothing moved for %0d cycles, %0d bytes still owed",
                     $time, STALL_LIMIT, frame_bytes_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // test sequence
    initial begin
        shadow_cfg = {DUTY_FLOOR_RST, DUTY_CEIL_RST, HEADER_FIRST_RST, HEADER_SECOND_RST,
                      FUNCTION_CODE_RST, COMMAND_CODE_RST};
        frame_open = 1'b0;
        entries_owed = '0;
        byte_sum = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_bad_counts();
        test_dropped_frames();
        test_config_extremes();
        test_random_frames();
        $display("sent %0d servo entries: %0d frames opened, %0d refused, %0d register writes",
                 entries_sent, frames_started, frames_refused, reg_writes);
        $display("compared %0d output bytes, %0d mismatches", bytes_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
